// ===== rtl/btff_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the boundary-tag first-fit allocator.
// Used by the top level; no dependencies.
package btff_pkg;

	localparam int HEAP_BYTES_DEF  = 65536;
	localparam int CHUNK_BYTES_DEF = 4096;
	localparam int TAG_W           = 32;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ZERO    = 2'd1;
	localparam logic [1:0] STAT_NO_HEAP = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [15:0] req_size;
		logic [15:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [15:0] granted_offset;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_FF_RD,
		ST_FF_CK,
		ST_GROW,
		ST_GW1,
		ST_GW2,
		ST_GW3,
		ST_MG_RS,
		ST_MG_RP,
		ST_MG_RN,
		ST_MG_RPS,
		ST_MG_PS,
		ST_MG_W1,
		ST_MG_W2,
		ST_PL_RD,
		ST_PL_CK,
		ST_PL_W1,
		ST_PL_W2,
		ST_PL_W3,
		ST_PL_W4,
		ST_FR_RD,
		ST_FR_CK,
		ST_FR_W1,
		ST_FR_W2,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/btff_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module btff_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/boundary_tag_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// Boundary-tag heap allocator, implicit free list, first fit.
// Depends on btff_pkg and btff_ram.
//
// Heap allocator over a tag RAM of HEAP_BYTES/4 words (HEAP_BYTES a power of two). After reset
// the block runs a clearing pass over every tag word that also lays down the prologue, the
// first free chunk and the epilogue; req_ready stays low until it ends. One request is handled
// at a time by a sequencer around the single tag RAM port pair. An allocate walks the blocks
// first fit, growing the break when none fits, then places the block and loads the result. A
// free checks its offset, then its header, then tags the block free and merges it with free
// neighbours; a refused offset or header ends it early. The result register lets the next
// request enter while the result waits; the done state stalls only while the previous result
// is still unread.
module boundary_tag_first_fit_allocator #(
	parameter int HEAP_BYTES  = btff_pkg::HEAP_BYTES_DEF,
	parameter int CHUNK_BYTES = btff_pkg::CHUNK_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  btff_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output btff_pkg::rsp_t  rsp
);

	localparam int WORDS    = HEAP_BYTES / 4;
	localparam int AW       = $clog2(WORDS);
	localparam int BRK_W    = $clog2(HEAP_BYTES + 1);
	localparam int INIT_SZ  = (((CHUNK_BYTES / 4) + 1) / 2) * 8;
	localparam bit INIT_OK  = (16 + INIT_SZ) <= HEAP_BYTES;
	localparam int FOOT_IDX = (16 + INIT_SZ - 8) / 4;
	localparam int EPI_IDX  = (16 + INIT_SZ - 4) / 4;
	localparam int INIT_BRK = INIT_OK ? (16 + INIT_SZ) : 16;

	btff_pkg::state_t state_q, state_nxt;

	logic [BRK_W-1:0] brk_q;
	logic [AW-1:0]    clr_q;
	logic [AW:0]      steps_q;
	logic [31:0]      bp_q, sz_q, acc_q, pbp_q, diff_q;
	logic [16:0]      asize_q;
	logic             pa_q, split_q, free_q, grant_q;
	logic [1:0]       stat_q;
	logic             rsp_valid_q;
	btff_pkg::rsp_t   rsp_q;

	logic             ram_we, clr_wr;
	logic [31:0]      wr_addr, wr_data, rd_addr, init_word;
	logic [AW-1:0]    ram_waddr;
	logic [31:0]      ram_rdata;

	logic [31:0] tag_sz, brk32, ff_next, ext, gsz, sz1, pl_diff, mg_acc;
	logic        fit, grow_fail, fr_ok, fr_tag_ok;
	logic [16:0] req_asize;
	logic [AW:0] steps_nxt;

	assign tag_sz    = {ram_rdata[31:3], 3'b000};
	assign brk32     = 32'(brk_q);
	assign ff_next   = bp_q + tag_sz;
	assign fit       = !ram_rdata[0] && (32'(asize_q) <= tag_sz);
	assign steps_nxt = steps_q + 1'b1;
	assign ext       = (32'(asize_q) > 32'(CHUNK_BYTES)) ? 32'(asize_q) : 32'(CHUNK_BYTES);
	assign gsz       = ((ext >> 2) + 32'd1) >> 1 << 3;
	assign grow_fail = (33'(brk_q) + 33'(gsz)) > 33'(HEAP_BYTES);
	assign sz1       = split_q ? 32'(asize_q) : sz_q;
	assign pl_diff   = tag_sz - 32'(asize_q);
	assign mg_acc    = sz_q + (ram_rdata[0] ? 32'd0 : tag_sz);
	assign req_asize = (req.req_size <= 16'd8) ? 17'd16
	                 : ((17'(req.req_size) + 17'd15) & ~17'd7);
	assign fr_ok     = (req.block_offset[2:0] == 3'd0) && (req.block_offset >= 16'd16)
	                 && (32'(req.block_offset) < brk32);
	assign fr_tag_ok = ram_rdata[0] && (tag_sz != 32'd0)
	                 && ((33'(bp_q) + 33'(tag_sz)) <= 33'(brk_q));

	always_comb begin
		init_word = 32'd0;
		if (clr_q == AW'(1) || clr_q == AW'(2)) begin
			init_word = 32'd9;
		end else if (clr_q == AW'(3)) begin
			init_word = INIT_OK ? 32'(INIT_SZ) : 32'd1;
		end else if (INIT_OK && clr_q == AW'(FOOT_IDX)) begin
			init_word = 32'(INIT_SZ);
		end else if (INIT_OK && clr_q == AW'(EPI_IDX)) begin
			init_word = 32'd1;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			btff_pkg::ST_CLR: begin
				if (clr_q == AW'(WORDS - 1)) state_nxt = btff_pkg::ST_IDLE;
			end
			btff_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.req_type == btff_pkg::REQ_FREE) begin
						state_nxt = fr_ok ? btff_pkg::ST_FR_RD : btff_pkg::ST_DONE;
					end else begin
						state_nxt = (req.req_size == 16'd0) ? btff_pkg::ST_DONE
						          : btff_pkg::ST_FF_RD;
					end
				end
			end
			btff_pkg::ST_FF_RD: state_nxt = btff_pkg::ST_FF_CK;
			btff_pkg::ST_FF_CK: begin
				if (tag_sz == 32'd0) state_nxt = btff_pkg::ST_GROW;
				else if (fit) state_nxt = btff_pkg::ST_PL_RD;
				else if (ff_next > brk32 || steps_nxt == (AW+1)'(WORDS))
					state_nxt = btff_pkg::ST_GROW;
				else state_nxt = btff_pkg::ST_FF_RD;
			end
			btff_pkg::ST_GROW: state_nxt = grow_fail ? btff_pkg::ST_DONE : btff_pkg::ST_GW1;
			btff_pkg::ST_GW1: state_nxt = btff_pkg::ST_GW2;
			btff_pkg::ST_GW2: state_nxt = btff_pkg::ST_GW3;
			btff_pkg::ST_GW3: state_nxt = btff_pkg::ST_MG_RS;
			btff_pkg::ST_MG_RS: state_nxt = btff_pkg::ST_MG_RP;
			btff_pkg::ST_MG_RP: state_nxt = btff_pkg::ST_MG_RN;
			btff_pkg::ST_MG_RN: state_nxt = btff_pkg::ST_MG_RPS;
			btff_pkg::ST_MG_RPS: begin
				if (pa_q && ram_rdata[0])
					state_nxt = free_q ? btff_pkg::ST_DONE : btff_pkg::ST_PL_RD;
				else if (pa_q) state_nxt = btff_pkg::ST_MG_W1;
				else state_nxt = btff_pkg::ST_MG_PS;
			end
			btff_pkg::ST_MG_PS: state_nxt = btff_pkg::ST_MG_W1;
			btff_pkg::ST_MG_W1: state_nxt = btff_pkg::ST_MG_W2;
			btff_pkg::ST_MG_W2: state_nxt = free_q ? btff_pkg::ST_DONE : btff_pkg::ST_PL_RD;
			btff_pkg::ST_PL_RD: state_nxt = btff_pkg::ST_PL_CK;
			btff_pkg::ST_PL_CK: state_nxt = btff_pkg::ST_PL_W1;
			btff_pkg::ST_PL_W1: state_nxt = btff_pkg::ST_PL_W2;
			btff_pkg::ST_PL_W2: state_nxt = split_q ? btff_pkg::ST_PL_W3 : btff_pkg::ST_DONE;
			btff_pkg::ST_PL_W3: state_nxt = btff_pkg::ST_PL_W4;
			btff_pkg::ST_PL_W4: state_nxt = btff_pkg::ST_DONE;
			btff_pkg::ST_FR_RD: state_nxt = btff_pkg::ST_FR_CK;
			btff_pkg::ST_FR_CK: state_nxt = fr_tag_ok ? btff_pkg::ST_FR_W1 : btff_pkg::ST_DONE;
			btff_pkg::ST_FR_W1: state_nxt = btff_pkg::ST_FR_W2;
			btff_pkg::ST_FR_W2: state_nxt = btff_pkg::ST_MG_RS;
			btff_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_nxt = btff_pkg::ST_IDLE;
			end
			default: state_nxt = btff_pkg::ST_IDLE;
		endcase
	end

	// tag RAM access and handshake
	always_comb begin
		ram_we    = 1'b0;
		clr_wr    = 1'b0;
		wr_addr   = 32'd0;
		wr_data   = 32'd0;
		rd_addr   = 32'd0;
		req_ready = 1'b0;
		unique case (state_q)
			btff_pkg::ST_CLR: begin
				ram_we  = 1'b1;
				clr_wr  = 1'b1;
				wr_data = init_word;
			end
			btff_pkg::ST_IDLE: req_ready = 1'b1;
			btff_pkg::ST_FF_RD, btff_pkg::ST_MG_RS, btff_pkg::ST_PL_RD, btff_pkg::ST_FR_RD: begin
				rd_addr = bp_q - 32'd4;
			end
			btff_pkg::ST_GW1, btff_pkg::ST_FR_W1: begin
				ram_we  = 1'b1;
				wr_addr = bp_q - 32'd4;
				wr_data = sz_q;
			end
			btff_pkg::ST_GW2, btff_pkg::ST_FR_W2: begin
				ram_we  = 1'b1;
				wr_addr = bp_q + sz_q - 32'd8;
				wr_data = sz_q;
			end
			btff_pkg::ST_GW3: begin
				ram_we  = 1'b1;
				wr_addr = bp_q + sz_q - 32'd4;
				wr_data = 32'd1;
			end
			btff_pkg::ST_MG_RP: rd_addr = bp_q - 32'd8;
			btff_pkg::ST_MG_RN: rd_addr = bp_q + sz_q - 32'd4;
			btff_pkg::ST_MG_RPS: rd_addr = pbp_q - 32'd4;
			btff_pkg::ST_MG_W1: begin
				ram_we  = 1'b1;
				wr_addr = bp_q - 32'd4;
				wr_data = acc_q;
			end
			btff_pkg::ST_MG_W2: begin
				ram_we  = 1'b1;
				wr_addr = bp_q + acc_q - 32'd8;
				wr_data = acc_q;
			end
			btff_pkg::ST_PL_W1: begin
				ram_we  = 1'b1;
				wr_addr = bp_q - 32'd4;
				wr_data = sz1 | 32'd1;
			end
			btff_pkg::ST_PL_W2: begin
				ram_we  = 1'b1;
				wr_addr = bp_q + sz1 - 32'd8;
				wr_data = sz1 | 32'd1;
			end
			btff_pkg::ST_PL_W3: begin
				ram_we  = 1'b1;
				wr_addr = bp_q + 32'(asize_q) - 32'd4;
				wr_data = diff_q;
			end
			btff_pkg::ST_PL_W4: begin
				ram_we  = 1'b1;
				wr_addr = bp_q + sz_q - 32'd8;
				wr_data = diff_q;
			end
			btff_pkg::ST_FF_CK, btff_pkg::ST_GROW, btff_pkg::ST_MG_PS, btff_pkg::ST_PL_CK,
			btff_pkg::ST_FR_CK, btff_pkg::ST_DONE: begin
				ram_we = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_waddr = clr_wr ? clr_q : wr_addr[AW+1:2];

	btff_ram #(
		.WIDTH (btff_pkg::TAG_W),
		.DEPTH (WORDS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_data),
		.raddr (rd_addr[AW+1:2]),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btff_pkg::ST_CLR;
			clr_q       <= '0;
			brk_q       <= BRK_W'(INIT_BRK);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == btff_pkg::ST_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == btff_pkg::ST_GROW && !grow_fail) brk_q <= BRK_W'(brk32 + gsz);
			if (state_q == btff_pkg::ST_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			btff_pkg::ST_IDLE: begin
				stat_q  <= btff_pkg::STAT_OK;
				grant_q <= 1'b0;
				free_q  <= req.req_type;
				asize_q <= req_asize;
				steps_q <= '0;
				bp_q    <= (req.req_type == btff_pkg::REQ_FREE) ? 32'(req.block_offset) : 32'd8;
				if (req.req_type == btff_pkg::REQ_ALLOC && req.req_size == 16'd0)
					stat_q <= btff_pkg::STAT_ZERO;
			end
			btff_pkg::ST_FF_CK: begin
				if (!(tag_sz == 32'd0) && !fit) begin
					bp_q    <= ff_next;
					steps_q <= steps_nxt;
				end
			end
			btff_pkg::ST_GROW: begin
				bp_q <= brk32;
				sz_q <= gsz;
				if (grow_fail) stat_q <= btff_pkg::STAT_NO_HEAP;
			end
			btff_pkg::ST_MG_RP: sz_q <= tag_sz;
			btff_pkg::ST_MG_RN: begin
				pa_q  <= ram_rdata[0];
				pbp_q <= bp_q - tag_sz;
			end
			btff_pkg::ST_MG_RPS: acc_q <= mg_acc;
			btff_pkg::ST_MG_PS: begin
				acc_q <= acc_q + tag_sz;
				bp_q  <= pbp_q;
			end
			btff_pkg::ST_PL_CK: begin
				sz_q    <= tag_sz;
				diff_q  <= pl_diff;
				split_q <= pl_diff > 32'd16;
			end
			btff_pkg::ST_PL_W2: if (!split_q) grant_q <= 1'b1;
			btff_pkg::ST_PL_W4: grant_q <= 1'b1;
			btff_pkg::ST_FR_CK: sz_q <= tag_sz;
			btff_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.granted_offset <= grant_q ? bp_q[15:0] : 16'd0;
					rsp_q.status         <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted but block still ready");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == btff_pkg::ST_IDLE |-> !ram_we)
		else $error("tag write while idle");

	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(brk_q) <= 32'(HEAP_BYTES) && brk_q[2:0] == 3'd0)
		else $error("break out of range or misaligned");

	a_grant_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted_offset != 16'd0 |->
		rsp.granted_offset[2:0] == 3'd0 && rsp.status == btff_pkg::STAT_OK)
		else $error("granted offset misaligned or with error status");
`endif

endmodule

// ===== dv/tb_boundary_tag_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the boundary-tag first-fit heap allocator.
// Depends on btff_pkg and the allocator RTL; keeps its own heap image to predict each response.
module tb_boundary_tag_first_fit_allocator;

	localparam int HEAP_B   = btff_pkg::HEAP_BYTES_DEF;
	localparam int CHUNK_B  = btff_pkg::CHUNK_BYTES_DEF;
	localparam int HWORDS   = HEAP_B / 4;
	localparam int N_RANDOM = 630;
	localparam int IDLE_LIMIT = 200000;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_ready;
	btff_pkg::req_t  req;
	logic            rsp_valid;
	logic            rsp_ready;
	btff_pkg::rsp_t  rsp;

	boundary_tag_first_fit_allocator #(.HEAP_BYTES(HEAP_B), .CHUNK_BYTES(CHUNK_B)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Heap image
	logic [31:0]     heap_img [HWORDS];
	logic [31:0]     brk;
	btff_pkg::rsp_t  pending_rsp [$];
	int              live_blocks [$];
	int              n_err, n_words, n_alloc, n_free, n_exhaust, idle_cnt;

	function automatic logic [31:0] hrd(logic [31:0] a);
		return heap_img[(a >> 2) % HWORDS];
	endfunction

	function automatic void hwr(logic [31:0] a, logic [31:0] v);
		heap_img[(a >> 2) % HWORDS] = v;
	endfunction

	function automatic logic [31:0] bsize(logic [31:0] bp);
		return hrd(bp - 4) & ~32'd7;
	endfunction

	function automatic void tag_block(logic [31:0] bp, logic [31:0] sz, logic [31:0] al);
		hwr(bp - 4, sz | al);
		hwr(bp + sz - 8, sz | al);
	endfunction

	function automatic logic [31:0] coalesce(logic [31:0] bp);
		logic [31:0] sz, psz, pbp, nbp, pft, nhd;
		logic pa, na;
		sz  = bsize(bp);
		pft = hrd(bp - 8);
		psz = pft & ~32'd7;
		pbp = bp - psz;
		nbp = bp + sz;
		nhd = hrd(nbp - 4);
		pa  = pft[0];
		na  = nhd[0];
		if (pa && na) return bp;
		if (pa) begin
			tag_block(bp, sz + bsize(nbp), 0);
			return bp;
		end
		if (na) begin
			tag_block(pbp, sz + bsize(pbp), 0);
			return pbp;
		end
		tag_block(pbp, sz + bsize(pbp) + bsize(nbp), 0);
		return pbp;
	endfunction

	function automatic logic [31:0] raise_break(logic [31:0] bytes);
		logic [31:0] sz, bp;
		sz = (((bytes / 4) + 1) & ~32'd1) * 4;
		bp = brk;
		if (64'(brk) + sz > HEAP_B) return 0;
		brk = bp + sz;
		tag_block(bp, sz, 0);
		hwr(bp + sz - 4, 1);
		return coalesce(bp);
	endfunction

	function automatic logic [31:0] scan_blocks(logic [31:0] asz);
		logic [31:0] bp, h, s;
		bp = 8;
		for (int i = 0; i < HWORDS; i++) begin
			h = hrd(bp - 4);
			s = h & ~32'd7;
			if (s == 0) return 0;
			if (!h[0] && asz <= s) return bp;
			bp += s;
			if (bp > brk) return 0;
		end
		return 0;
	endfunction

	function automatic void heap_reset();
		foreach (heap_img[i]) heap_img[i] = 0;
		hwr(4, 9);
		hwr(8, 9);
		hwr(12, 1);
		brk = 16;
		void'(raise_break(CHUNK_B));
	endfunction

	function automatic btff_pkg::rsp_t predict_alloc_free(btff_pkg::req_t r);
		btff_pkg::rsp_t o;
		logic [31:0] asz, bp, csz, off, h, s;
		o = '0;
		if (r.req_type == btff_pkg::REQ_ALLOC) begin
			if (r.req_size == 0) begin
				o.status = btff_pkg::STAT_ZERO;
			end else begin
				asz = (r.req_size <= 8) ? 16 : 8 * ((32'(r.req_size) + 15) / 8);
				bp = scan_blocks(asz);
				if (bp == 0) bp = raise_break(asz > CHUNK_B ? asz : CHUNK_B);
				if (bp == 0) begin
					o.status = btff_pkg::STAT_NO_HEAP;
				end else begin
					csz = bsize(bp);
					if (csz - asz > 16) begin
						tag_block(bp, asz, 1);
						tag_block(bp + asz, csz - asz, 0);
					end else begin
						tag_block(bp, csz, 1);
					end
					o.granted_offset = bp[15:0];
				end
			end
		end else begin
			off = 32'(r.block_offset);
			if (off[2:0] == 0 && off >= 16 && off < brk) begin
				h = hrd(off - 4);
				s = h & ~32'd7;
				if (h[0] && s != 0 && 64'(off) + s <= brk) begin
					tag_block(off, s, 0);
					void'(coalesce(off));
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
		n_err++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall pattern with quiet stretches
	initial begin
		int phase;
		rsp_ready = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if ((phase / 300) % 3 == 2) rsp_ready <= 1'b1;
			else rsp_ready <= ($urandom_range(0, 99) < 60);
		end
	end

	// Response checker and watchdog
	always @(posedge clk) begin
		btff_pkg::rsp_t want;
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cnt <= 0;
			else idle_cnt <= idle_cnt + 1;
			if (rsp_valid && rsp_ready) begin
				n_words++;
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected word", rsp, 0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.granted_offset !== want.granted_offset)
						report_mismatch("granted_offset", rsp.granted_offset, want.granted_offset);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
				end
			end
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Directed row: a request plus an optional typed-in answer
	typedef struct {
		btff_pkg::req_t r;
		logic           fixed;
		btff_pkg::rsp_t ans;
	} row_t;

	task automatic send_word(btff_pkg::req_t r, logic fixed, btff_pkg::rsp_t ans);
		btff_pkg::rsp_t p;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		p = predict_alloc_free(r);
		if (fixed && p !== ans)
			report_mismatch("predictor vs table", p, ans);
		pending_rsp.push_back(fixed ? ans : p);
		if (r.req_type == btff_pkg::REQ_ALLOC && p.status == btff_pkg::STAT_OK
		    && p.granted_offset != 0) begin
			live_blocks.push_back(p.granted_offset);
			n_alloc++;
		end
		if (r.req_type == btff_pkg::REQ_FREE) n_free++;
		if (p.status == btff_pkg::STAT_NO_HEAP) n_exhaust++;
	endtask

	// Sender pacing: bursts, then random gaps
	int burst_left;
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		req_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
		burst_left = $urandom_range(0, 20);
	endtask

	function automatic btff_pkg::req_t mk(logic t, int sz, int off);
		btff_pkg::req_t r;
		r.req_type = t;
		r.req_size = sz[15:0];
		r.block_offset = off[15:0];
		return r;
	endfunction

	function automatic btff_pkg::rsp_t ok(int off, logic [1:0] st);
		btff_pkg::rsp_t o;
		o.granted_offset = off[15:0];
		o.status = st;
		return o;
	endfunction

	initial begin
		row_t dir_rows [$];
		btff_pkg::req_t r;
		int k, idx, wait_cyc;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		n_err = 0;
		n_words = 0;
		n_alloc = 0;
		n_free = 0;
		n_exhaust = 0;
		idle_cnt = 0;
		burst_left = 0;
		heap_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// After reset the first fit lands at offset 16
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 0, 0), 1, ok(0, btff_pkg::STAT_ZERO)});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 1, 0), 1, ok(16, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 8, 0), 1, ok(32, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 9, 0), 1, ok(48, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 32), 1, ok(0, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 5, 0), 1, ok(32, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 36), 1, ok(0, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 8), 1, ok(0, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 0), 1, ok(0, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 65528), 1, ok(0, btff_pkg::STAT_OK)});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 16), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 16), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 48), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 32), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 4000, 0), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 5000, 0), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 65535, 0), 1,
			ok(0, btff_pkg::STAT_NO_HEAP)});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 30000, 0), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 30000, 0), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 65535), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_FREE, 0, 4112), 0, '0});
		dir_rows.push_back('{mk(btff_pkg::REQ_ALLOC, 24, 0), 0, '0});

		@(posedge clk);
		foreach (dir_rows[i]) begin
			pace();
			send_word(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].ans);
		end

		for (k = 0; k < N_RANDOM; k++) begin
			pace();
			r = '0;
			case ($urandom_range(0, 99)) inside
				[0:44]: begin
					r.req_type = btff_pkg::REQ_ALLOC;
					r.req_size = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
						: 16'($urandom_range(1, 600));
				end
				[45:84]: begin
					r.req_type = btff_pkg::REQ_FREE;
					if (live_blocks.size() > 0) begin
						idx = $urandom_range(0, live_blocks.size() - 1);
						r.block_offset = 16'(live_blocks[idx]);
						live_blocks.delete(idx);
					end
					r.req_size = 16'($urandom);
				end
				[85:92]: begin
					// junk free: random offset and size bits
					r.req_type = btff_pkg::REQ_FREE;
					r.req_size = 16'($urandom);
					r.block_offset = 16'($urandom);
				end
				default: begin
					r.req_type = btff_pkg::REQ_ALLOC;
					r.req_size = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
					r.block_offset = 16'($urandom);
				end
			endcase
			send_word(r, 0, '0);
		end
		req_valid <= 1'b0;

		wait_cyc = 0;
		while (pending_rsp.size() != 0 && wait_cyc < IDLE_LIMIT) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (100) @(posedge clk);
		if (pending_rsp.size() != 0) n_err++;

		$display("covered %0d words: %0d grants, %0d frees, %0d exhaust answers",
			n_words, n_alloc, n_free, n_exhaust);
		if (n_err == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", n_err);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
